// ===== src/dstq_pkg.sv =====
// Shared types and constants for the deadline-sorted timer queue.
// Used by the timed cell, the instant cell and the top level.
package dstq_pkg;

	// Entries per queue and count width
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	// Field widths
	localparam int OP_W  = 2;
	localparam int HND_W = 16;
	localparam int TIM_W = 32;

	// Opcodes
	localparam logic [OP_W-1:0] OP_ADD_TIMED   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD_INSTANT = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK        = 2'd2;

	// Result codes
	localparam logic KIND_STATUS   = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_FULL   = 1'b1;
	localparam logic SRC_INSTANT   = 1'b0;
	localparam logic SRC_TIMED     = 1'b1;

	// Command broadcast to every timed cell
	typedef struct packed {
		logic             ins;
		logic             pop;
		logic [TIM_W-1:0] dl;
		logic [HND_W-1:0] h;
	} tcmd_t;

	// Command broadcast to every instant cell
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [HND_W-1:0] h;
	} icmd_t;

	// One result beat
	typedef struct packed {
		logic             kind;
		logic             status;
		logic             source;
		logic [HND_W-1:0] handle_out;
		logic             last;
	} result_t;

endpackage

// ===== src/dstq_tcell.sv =====
// One cell of the deadline-sorted chain: holds a deadline and a handle.
// Depends on dstq_pkg for the command type and field widths.
module dstq_tcell (
	input  logic                            clk,
	input  dstq_pkg::tcmd_t                 cmd,
	input  logic                            occ,
	input  logic                            left_after,
	input  logic [dstq_pkg::TIM_W-1:0]      left_dl,
	input  logic [dstq_pkg::HND_W-1:0]      left_h,
	input  logic [dstq_pkg::TIM_W-1:0]      right_dl,
	input  logic [dstq_pkg::HND_W-1:0]      right_h,
	output logic [dstq_pkg::TIM_W-1:0]      dl,
	output logic [dstq_pkg::HND_W-1:0]      h,
	output logic                            after
);
	import dstq_pkg::*;

	logic [TIM_W-1:0] dl_q;
	logic [HND_W-1:0] h_q;

	// Flag cells at or past the insert point: empty, or strictly later
	assign after = !occ || (dl_q > cmd.dl);

	// Shift right behind the insert point, take the new beat at it, shift left on pop
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_after) begin
				dl_q <= left_dl;
				h_q  <= left_h;
			end else if (after) begin
				dl_q <= cmd.dl;
				h_q  <= cmd.h;
			end
		end else if (cmd.pop) begin
			dl_q <= right_dl;
			h_q  <= right_h;
		end
	end

	assign dl = dl_q;
	assign h  = h_q;

endmodule

// ===== src/dstq_icell.sv =====
// One cell of the instant FIFO chain: holds a single handle.
// Depends on dstq_pkg for the command type and field widths.
module dstq_icell (
	input  logic                       clk,
	input  dstq_pkg::icmd_t            cmd,
	input  logic                       occ,
	input  logic                       left_occ,
	input  logic [dstq_pkg::HND_W-1:0] right_h,
	output logic [dstq_pkg::HND_W-1:0] h
);
	import dstq_pkg::*;

	logic [HND_W-1:0] h_q;

	// Write the tail cell on push, shift toward the head on pop
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (left_occ && !occ)
				h_q <= cmd.h;
		end else if (cmd.pop) begin
			h_q <= right_h;
		end
	end

	assign h = h_q;

endmodule

// ===== src/deadline_sorted_timer_queue_core.sv =====
// Top level of the deadline-sorted timer queue: command port, two cell chains, result beats.
// Depends on dstq_pkg, dstq_tcell and dstq_icell.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  command  | start in, busy out     | opcode, handle, delay, now
//  result   | strobe out, no stall   | kind, status, source, handle_out, last
//
// A command is taken when start is high and busy is low; its chain operations happen in that cycle.
// The first result beat shows in the cycle after the command; a tick dispatching from both
// queues shows its second beat in the next cycle, and busy is high for that one cycle.
// So busy holds off new commands only while the second beat of a double dispatch is pending.
// Reset clears both counts and the result control; cell contents are left as they are.
// Results cannot be stalled: each beat holds for exactly one cycle.
module deadline_sorted_timer_queue_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [dstq_pkg::OP_W-1:0]  opcode,
	input  logic [dstq_pkg::HND_W-1:0] handle,
	input  logic [dstq_pkg::TIM_W-1:0] delay,
	input  logic [dstq_pkg::TIM_W-1:0] now,
	output logic                       strobe,
	output logic                       kind,
	output logic                       status,
	output logic                       source,
	output logic [dstq_pkg::HND_W-1:0] handle_out,
	output logic                       last
);
	import dstq_pkg::*;

	logic             accept;
	logic [CNT_W-1:0] tcount_q;
	logic [CNT_W-1:0] icount_q;
	logic             tfull;
	logic             ifull;
	logic             t_due;
	logic             pend_q;
	logic [HND_W-1:0] pend_h_q;
	logic             strobe_q;
	logic             res_valid;
	logic             set_pend;
	result_t          res_d;
	result_t          res_q;
	tcmd_t            tcmd;
	icmd_t            icmd;

	logic [DEPTH-1:0] t_occ;
	logic [DEPTH-1:0] i_occ;
	logic [DEPTH-1:0] t_after;
	logic [TIM_W-1:0] t_dl [DEPTH];
	logic [HND_W-1:0] t_h  [DEPTH];
	logic [HND_W-1:0] i_h  [DEPTH];

	assign busy   = pend_q;
	assign accept = start && !busy;
	assign tfull  = (tcount_q == CNT_W'(DEPTH));
	assign ifull  = (icount_q == CNT_W'(DEPTH));
	assign t_due  = (tcount_q != '0) && (t_dl[0] <= now);

	// Decode the command into chain operations
	always_comb begin
		tcmd.ins  = accept && (opcode == OP_ADD_TIMED) && !tfull;
		tcmd.pop  = accept && (opcode == OP_TICK) && t_due;
		tcmd.dl   = now + delay;
		tcmd.h    = handle;
		icmd.push = accept && (opcode == OP_ADD_INSTANT) && !ifull;
		icmd.pop  = accept && (opcode == OP_TICK) && (icount_q != '0);
		icmd.h    = handle;
	end

	// Derive occupancy of each cell from the counts
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			t_occ[i] = CNT_W'(i) < tcount_q;
			i_occ[i] = CNT_W'(i) < icount_q;
		end
	end

	// Build both chains
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             l_after;
		logic [TIM_W-1:0] l_dl;
		logic [HND_W-1:0] l_h;
		logic [TIM_W-1:0] r_dl;
		logic [HND_W-1:0] r_h;
		logic             l_iocc;
		logic [HND_W-1:0] r_ih;

		if (i == 0) begin : g_head
			assign l_after = 1'b0;
			assign l_dl    = '0;
			assign l_h     = '0;
			assign l_iocc  = 1'b1;
		end else begin : g_body
			assign l_after = t_after[i-1];
			assign l_dl    = t_dl[i-1];
			assign l_h     = t_h[i-1];
			assign l_iocc  = i_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_dl = '0;
			assign r_h  = '0;
			assign r_ih = '0;
		end else begin : g_mid
			assign r_dl = t_dl[i+1];
			assign r_h  = t_h[i+1];
			assign r_ih = i_h[i+1];
		end

		dstq_tcell u_tcell (
			.clk        (clk),
			.cmd        (tcmd),
			.occ        (t_occ[i]),
			.left_after (l_after),
			.left_dl    (l_dl),
			.left_h     (l_h),
			.right_dl   (r_dl),
			.right_h    (r_h),
			.dl         (t_dl[i]),
			.h          (t_h[i]),
			.after      (t_after[i])
		);

		dstq_icell u_icell (
			.clk      (clk),
			.cmd      (icmd),
			.occ      (i_occ[i]),
			.left_occ (l_iocc),
			.right_h  (r_ih),
			.h        (i_h[i])
		);
	end

	// Advance the counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= '0;
			icount_q <= '0;
		end else begin
			if (tcmd.ins)
				tcount_q <= tcount_q + CNT_W'(1);
			else if (tcmd.pop)
				tcount_q <= tcount_q - CNT_W'(1);
			if (icmd.push)
				icount_q <= icount_q + CNT_W'(1);
			else if (icmd.pop)
				icount_q <= icount_q - CNT_W'(1);
		end
	end

	// Form the next result beat
	always_comb begin
		res_d     = '0;
		res_valid = 1'b0;
		set_pend  = 1'b0;
		if (pend_q) begin
			res_valid      = 1'b1;
			res_d.kind     = KIND_DISPATCH;
			res_d.status   = STATUS_OK;
			res_d.source   = SRC_TIMED;
			res_d.handle_out = pend_h_q;
			res_d.last     = 1'b1;
		end else if (accept) begin
			unique case (opcode)
				OP_ADD_TIMED: begin
					res_valid    = 1'b1;
					res_d.kind   = KIND_STATUS;
					res_d.status = tfull ? STATUS_FULL : STATUS_OK;
					res_d.last   = 1'b1;
				end
				OP_ADD_INSTANT: begin
					res_valid    = 1'b1;
					res_d.kind   = KIND_STATUS;
					res_d.status = ifull ? STATUS_FULL : STATUS_OK;
					res_d.last   = 1'b1;
				end
				OP_TICK: begin
					res_valid = icmd.pop || tcmd.pop;
					res_d.kind = KIND_DISPATCH;
					res_d.status = STATUS_OK;
					if (icmd.pop) begin
						res_d.source     = SRC_INSTANT;
						res_d.handle_out = i_h[0];
						res_d.last       = !tcmd.pop;
						set_pend         = tcmd.pop;
					end else begin
						res_d.source     = SRC_TIMED;
						res_d.handle_out = t_h[0];
						res_d.last       = 1'b1;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// Hold the result control and the pending second beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			strobe_q <= res_valid;
			pend_q   <= set_pend;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (set_pend)
			pend_h_q <= t_h[0];
	end

	assign strobe     = strobe_q;
	assign kind       = res_q.kind;
	assign status     = res_q.status;
	assign source     = res_q.source;
	assign handle_out = res_q.handle_out;
	assign last       = res_q.last;

	// A pending timed beat always sits behind an instant beat on the port
	a_pend_behind_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (strobe && !last && source == SRC_INSTANT))
		else $error("pending beat without a leading instant beat");

	// A beat without last is always followed by a last timed beat
	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> (strobe && last && source == SRC_TIMED))
		else $error("missing second dispatch beat");

	// Counts never exceed the chain length
	a_tcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		tcount_q <= CNT_W'(DEPTH))
		else $error("timed count overflow");

	a_icount_range: assert property (@(posedge clk) disable iff (!arst_n)
		icount_q <= CNT_W'(DEPTH))
		else $error("instant count overflow");

	// A timed dispatch comes only from an occupied head that was due
	a_timed_pop_due: assert property (@(posedge clk) disable iff (!arst_n)
		tcmd.pop |-> (tcount_q != '0 && t_dl[0] <= now))
		else $error("timed pop of an empty or undue head");

endmodule
